@@ rtl/sptl_pkg.sv @@
package sptl_pkg;

    // Table geometry and field widths.
    localparam int TableDepth = 4096;
    localparam int GlyphBits  = 16;
    localparam int AdvBits    = 16;
    localparam int IdxBits    = $clog2(TableDepth);
    localparam int CntBits    = $clog2(TableDepth + 1);
    localparam int EntryBits  = 2 * GlyphBits + AdvBits;

    // Transaction kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind KindLoad  = 2'd0;
    localparam t_kind KindQuery = 2'd1;
    localparam t_kind KindClear = 2'd2;

    // Search sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_FINAL
    } t_state;

    // Query request from the front end to the search sequencer.
    typedef struct packed {
        logic                 valid;
        logic [GlyphBits-1:0] first;
        logic [GlyphBits-1:0] second;
    } t_search_req;

    // Query response from the search sequencer.
    typedef struct packed {
        logic               valid;
        logic [AdvBits-1:0] advance;
        logic               found;
    } t_search_rsp;

endpackage

@@ rtl/sptl_ram.sv @@
module sptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sptl_search.sv @@
module sptl_search
    import sptl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_search_req          i_req,
    input  logic [CntBits-1:0]   i_count,
    input  logic [EntryBits-1:0] i_rdata,
    output logic [IdxBits-1:0]   o_raddr,
    output logic                 o_busy,
    output t_search_rsp          o_rsp
);

    t_state               r_state, n_state;
    logic [CntBits-1:0]   r_lo, n_lo;
    logic [CntBits-1:0]   r_span, n_span;
    logic [CntBits-1:0]   r_mid, n_mid;
    logic [GlyphBits-1:0] r_key_first, n_key_first;
    logic [GlyphBits-1:0] r_key_second, n_key_second;
    logic                 r_rsp_valid, n_rsp_valid;
    logic [AdvBits-1:0]   r_rsp_adv, n_rsp_adv;
    logic                 r_rsp_found, n_rsp_found;

    logic [GlyphBits-1:0] ent_first;
    logic [GlyphBits-1:0] ent_second;
    logic [AdvBits-1:0]   ent_adv;
    logic                 ent_less;
    logic                 ent_equal;
    logic [CntBits-1:0]   half;
    logic [CntBits-1:0]   cand_lo;
    logic [CntBits-1:0]   cand_span;
    logic [CntBits-1:0]   cand_mid;
    logic                 issue;

    // Unpack the entry returned by the memory.
    assign ent_first  = i_rdata[EntryBits-1 -: GlyphBits];
    assign ent_second = i_rdata[AdvBits +: GlyphBits];
    assign ent_adv    = i_rdata[AdvBits-1:0];

    // Lexicographic compare of the entry against the key.
    assign ent_less  = (ent_first < r_key_first) ||
                       ((ent_first == r_key_first) && (ent_second < r_key_second));
    assign ent_equal = (ent_first == r_key_first) && (ent_second == r_key_second);

    assign half     = r_span >> 1;
    assign cand_mid = cand_lo + (cand_span >> 1);

    // State register and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Search payload registers.
    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_span       <= n_span;
        r_mid        <= n_mid;
        r_key_first  <= n_key_first;
        r_key_second <= n_key_second;
        r_rsp_adv    <= n_rsp_adv;
        r_rsp_found  <= n_rsp_found;
    end

    // Next state: each step compares the returned entry and issues the next read
    // in the same cycle.
    always_comb begin
        n_state      = r_state;
        n_lo         = r_lo;
        n_span       = r_span;
        n_mid        = r_mid;
        n_key_first  = r_key_first;
        n_key_second = r_key_second;
        n_rsp_valid  = 1'b0;
        n_rsp_adv    = r_rsp_adv;
        n_rsp_found  = r_rsp_found;
        cand_lo      = r_lo;
        cand_span    = r_span;
        issue        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key_first  = i_req.first;
                    n_key_second = i_req.second;
                    cand_lo      = '0;
                    cand_span    = i_count;
                    issue        = 1'b1;
                end
            end
            S_STEP: begin
                if (ent_less) begin
                    cand_lo   = r_mid + CntBits'(1);
                    cand_span = r_span - half - CntBits'(1);
                end else begin
                    cand_lo   = r_lo;
                    cand_span = half;
                end
                issue = 1'b1;
            end
            S_FINAL: begin
                n_rsp_valid = 1'b1;
                n_rsp_found = ent_equal;
                n_rsp_adv   = ent_equal ? ent_adv : '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Decide the next read: another probe, the landing entry, or a miss.
        if (issue) begin
            n_lo   = cand_lo;
            n_span = cand_span;
            n_mid  = cand_mid;
            if (cand_span != '0) begin
                n_state = S_STEP;
            end else if (cand_lo < i_count) begin
                n_state = S_FINAL;
            end else begin
                n_rsp_valid = 1'b1;
                n_rsp_found = 1'b0;
                n_rsp_adv   = '0;
                n_state     = S_IDLE;
            end
        end
    end

    // The landing read uses the lower bound itself; probes use the midpoint.
    assign o_raddr = (cand_span != '0) ? cand_mid[IdxBits-1:0] : cand_lo[IdxBits-1:0];
    assign o_busy  = (r_state != S_IDLE);

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.advance = r_rsp_adv;
    assign o_rsp.found   = r_rsp_found;

endmodule

@@ rtl/sorted_pair_table_lookup.sv @@
// Load and clear transactions return nothing.
// A query walks a lower-bound bisection, one table read per step.
// A query on an empty table strobes in the cycle after acceptance; busy covers the search.
// The single read port of the table memory sets the pace; the receiver cannot stall.
// Synchronous active-low reset empties the table; entry contents are not cleared.
module sorted_pair_table_lookup
    import sptl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_kind,
    input  logic [15:0]                 i_first_glyph,
    input  logic [15:0]                 i_second_glyph,
    input  logic signed [15:0]          i_load_advance,
    output logic                        o_strobe,
    output logic signed [15:0]          o_kern_advance,
    output logic                        o_found
);

    logic [CntBits-1:0]   r_count, n_count;
    logic                 accept;
    logic                 wr_en;
    logic [EntryBits-1:0] wr_data;
    logic [IdxBits-1:0]   rd_addr;
    logic [EntryBits-1:0] rd_data;
    logic                 search_busy;
    t_search_req          req;
    t_search_rsp          rsp;

    assign accept = i_start && !search_busy;

    // Decode the transaction kind: append, search or empty the table.
    always_comb begin
        n_count    = r_count;
        wr_en      = 1'b0;
        req.valid  = 1'b0;
        req.first  = i_first_glyph[GlyphBits-1:0];
        req.second = i_second_glyph[GlyphBits-1:0];
        if (accept) begin
            unique case (t_kind'(i_kind))
                KindLoad: begin
                    if (r_count < CntBits'(TableDepth)) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CntBits'(1);
                    end
                end
                KindQuery: begin
                    req.valid = 1'b1;
                end
                KindClear: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign wr_data    = {i_first_glyph[GlyphBits-1:0], i_second_glyph[GlyphBits-1:0],
                         i_load_advance};

    // Entry count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Pair table storage.
    sptl_ram #(
        .WIDTH (EntryBits),
        .DEPTH (TableDepth)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IdxBits-1:0]),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Bisection sequencer.
    sptl_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_count (r_count),
        .i_rdata (rd_data),
        .o_raddr (rd_addr),
        .o_busy  (search_busy),
        .o_rsp   (rsp)
    );

    assign o_busy         = search_busy;
    assign o_strobe       = rsp.valid;
    assign o_kern_advance = rsp.advance;
    assign o_found        = rsp.found;

endmodule
